>>> hw/rtl/rpte_pkg.sv
// rpte_pkg: shared codes, payload structs and controller/datapath link types
// for the register protocol transaction engine. no dependencies.
package rpte_pkg;

   localparam int MAX_WORDS_DEFAULT = 32;

   // input command codes
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_WDATA = 2'd1;
   localparam logic [1:0] CMD_RESP  = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_REQ   = 2'd0;
   localparam logic [1:0] KIND_RDATA = 2'd1;
   localparam logic [1:0] KIND_CPL   = 2'd2;

   // completion status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_SIZE = 2'd1;
   localparam logic [1:0] STATUS_NO_SPACE = 2'd2;
   localparam logic [1:0] STATUS_REMOTE   = 2'd3;

   // request sizing
   localparam logic [15:0] MIN_BYTES       = 16'd4;
   localparam logic [16:0] WRITE_HDR_BYTES = 17'd12;
   localparam logic [16:0] READ_REQ_BYTES  = 17'd16;
   localparam logic [15:0] RX_POS_MAX      = 16'hFFFF;
   localparam logic [16:0] RSP_OVERHEAD    = 17'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] tid;
      logic [31:0] address;
      logic [15:0] transfer_bytes;
      logic        is_write;
      logic        posted;
      logic [15:0] tx_space_bytes;
      logic [31:0] data_word;
      logic        rx_last;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] word;
      logic        frame_end;
      logic [1:0]  status;
      logic [31:0] remote_code;
      logic        last;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_CTX,
      EMIT_ADDR,
      EMIT_COUNT,
      EMIT_TAIL,
      EMIT_WDATA,
      EMIT_RDATA,
      EMIT_CPL
   } emit_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_HDR0,
      ST_HDR1,
      ST_COUNT,
      ST_TAIL,
      ST_WDATA,
      ST_FETCH,
      ST_RDATA,
      ST_CPL
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic         capture;
      logic         exec;
      logic         fetch;
      logic         rd_clear;
      emit_sel_type emit;
      logic         emit_last;
      logic [1:0]   cpl_status;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] command;
      logic       bad_size;
      logic       no_space;
      logic       wdata_ok;
      logic       rsp_ok;
      logic       frame_done;
      logic       remote;
      logic       write_mode;
      logic       posted_mode;
      logic       tx_done;
      logic       rd_last;
      logic       out_free;
   } stat_type;

endpackage

>>> hw/rtl/rpte_chan_if.sv
// rpte_chan_if: valid/ready channel carrying one payload struct per transfer.
// payload type is set by the instantiating level (rpte_pkg structs).
interface rpte_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/register_protocol_transaction_engine_core.sv
// register_protocol_transaction_engine_core: top level of the register
// transaction engine. depends on rpte_pkg, rpte_chan_if, rpte_controller, rpte_datapath.
//
//  channel   dir   modport   payload                       transfer when
//  req_if    in    sink      rpte_pkg::req_payload_type    valid & ready
//  rsp_if    out   source    rpte_pkg::rsp_payload_type    valid & ready
//
// one item at a time: accept, then decode and state update,
//   then each result in order while the output register drains
// read-data flush passes each word through the buffer read port, then emits it
// item without results goes from decode straight back to accept
// synchronous active-high reset; read buffer is not cleared, only filled
// output stall holds the sequencer in its current emit step
module register_protocol_transaction_engine_core #(
   parameter int MAX_WORDS = rpte_pkg::MAX_WORDS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   rpte_chan_if.sink   req_if,
   rpte_chan_if.source rsp_if
);

   // controller <-> datapath link
   rpte_pkg::ctl_type  ctl;
   rpte_pkg::stat_type stat;

   // sequencer: owns the request handshake and the emit order
   rpte_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   // transaction state, read buffer and output register
   rpte_datapath #(
      .MAX_WORDS (MAX_WORDS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_if.payload),
      .ctl         (ctl),
      .stat        (stat),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_payload (rsp_if.payload)
   );

endmodule

>>> hw/rtl/rpte_datapath.sv
// rpte_datapath: transaction state, size checks, read buffer memory and
// result output register. depends on rpte_pkg.
module rpte_datapath #(
   parameter int MAX_WORDS = rpte_pkg::MAX_WORDS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  rpte_pkg::req_payload_type  req_payload,
   input  rpte_pkg::ctl_type          ctl,
   output rpte_pkg::stat_type         stat,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rpte_pkg::rsp_payload_type  rsp_payload
);

   localparam int CW = $clog2(MAX_WORDS + 1);
   localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam logic [16:0] MAX_BYTES = 17'(MAX_WORDS * 4);

   rpte_pkg::req_payload_type item_ff;
   logic             busy_ff, busy_in;
   logic             write_mode_ff, write_mode_in;
   logic             posted_mode_ff, posted_mode_in;
   logic [31:0]      context_ff, context_in;
   logic [31:0]      address_ff, address_in;
   logic [CW-1:0]    word_count_ff, word_count_in;
   logic [CW-1:0]    tx_sent_ff, tx_sent_in;
   logic [15:0]      rx_pos_ff, rx_pos_in;
   logic             header_ok_ff, header_ok_in;
   logic [CW-1:0]    rd_idx_ff, rd_idx_in;
   logic [31:0]      rd_data_ff;
   logic [31:0]      mem [MAX_WORDS];
   logic             mem_we;
   rpte_pkg::rsp_payload_type out_ff, out_in;
   logic             out_valid_ff, out_valid_in;

   logic [16:0]      size_ext;
   logic [16:0]      need_bytes;
   logic             bad_size;
   logic             no_space;
   logic [CW-1:0]    new_count;
   logic [CW-1:0]    tx_sent_inc;
   logic             wdata_ok;
   logic             rsp_ok;
   logic             header_next;
   logic [15:0]      buf_pos;
   logic [AW-1:0]    buf_idx;
   logic             buf_hit;
   logic [16:0]      frame_total;
   logic             frame_done;
   logic             out_free;

   // start checks
   assign size_ext   = {1'b0, item_ff.transfer_bytes};
   assign bad_size   = (item_ff.transfer_bytes[1:0] != 2'b00) ||
                       (item_ff.transfer_bytes < rpte_pkg::MIN_BYTES) ||
                       (size_ext > MAX_BYTES);
   assign need_bytes = item_ff.is_write ? size_ext + rpte_pkg::WRITE_HDR_BYTES
                                        : rpte_pkg::READ_REQ_BYTES;
   assign no_space   = {1'b0, item_ff.tx_space_bytes} < need_bytes;
   assign new_count  = CW'(item_ff.transfer_bytes >> 2);

   // write data
   assign wdata_ok    = busy_ff && write_mode_ff && (tx_sent_ff < word_count_ff);
   assign tx_sent_inc = tx_sent_ff + CW'(1);

   // response frame
   assign rsp_ok = busy_ff && !posted_mode_ff &&
                   (!write_mode_ff || (tx_sent_ff == word_count_ff));

   always_comb begin
      if (rx_pos_ff == 16'd0) begin
         header_next = (item_ff.data_word == context_ff);
      end else if (rx_pos_ff == 16'd1) begin
         header_next = header_ok_ff && (item_ff.data_word == address_ff);
      end else begin
         header_next = header_ok_ff;
      end
   end

   assign buf_pos     = rx_pos_ff - 16'd2;
   assign buf_idx     = buf_pos[AW-1:0];
   assign buf_hit     = !write_mode_ff && (rx_pos_ff >= 16'd2) &&
                        (buf_pos < 16'(word_count_ff));
   assign frame_total = {1'b0, rx_pos_ff} + 17'd1;
   assign frame_done  = item_ff.rx_last && header_next &&
                        (frame_total >= 17'(word_count_ff) + rpte_pkg::RSP_OVERHEAD);

   // state update on exec
   always_comb begin
      busy_in        = busy_ff;
      write_mode_in  = write_mode_ff;
      posted_mode_in = posted_mode_ff;
      context_in     = context_ff;
      address_in     = address_ff;
      word_count_in  = word_count_ff;
      tx_sent_in     = tx_sent_ff;
      rx_pos_in      = rx_pos_ff;
      header_ok_in   = header_ok_ff;
      mem_we         = 1'b0;
      if (ctl.exec) begin
         unique case (item_ff.command)
            rpte_pkg::CMD_START: begin
               busy_in      = 1'b0;
               rx_pos_in    = 16'd0;
               header_ok_in = 1'b0;
               tx_sent_in   = '0;
               if (!bad_size && !no_space) begin
                  write_mode_in  = item_ff.is_write;
                  posted_mode_in = item_ff.posted;
                  word_count_in  = new_count;
                  context_in     = item_ff.tid;
                  address_in     = {1'b0, item_ff.is_write, item_ff.address[31:2]};
                  busy_in        = item_ff.is_write || !item_ff.posted;
               end
            end
            rpte_pkg::CMD_WDATA: begin
               if (wdata_ok) begin
                  tx_sent_in = tx_sent_inc;
                  if ((tx_sent_inc == word_count_ff) && posted_mode_ff) begin
                     busy_in = 1'b0;
                  end
               end
            end
            rpte_pkg::CMD_RESP: begin
               if (rsp_ok) begin
                  mem_we = buf_hit;
                  if (item_ff.rx_last) begin
                     rx_pos_in    = 16'd0;
                     header_ok_in = 1'b0;
                     if (frame_done) begin
                        busy_in = 1'b0;
                     end
                  end else begin
                     header_ok_in = header_next;
                     if (rx_pos_ff != rpte_pkg::RX_POS_MAX) begin
                        rx_pos_in = rx_pos_ff + 16'd1;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // read index walks the buffer during the flush
   always_comb begin
      rd_idx_in = rd_idx_ff;
      if (ctl.rd_clear) begin
         rd_idx_in = '0;
      end else if (ctl.emit == rpte_pkg::EMIT_RDATA) begin
         rd_idx_in = rd_idx_ff + CW'(1);
      end
   end

   // result register
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_in             = out_ff;
      out_valid_in       = out_valid_ff && !rsp_ready;
      if (ctl.emit != rpte_pkg::EMIT_NONE) begin
         out_valid_in       = 1'b1;
         out_in.kind        = rpte_pkg::KIND_REQ;
         out_in.word        = 32'd0;
         out_in.frame_end   = 1'b0;
         out_in.status      = rpte_pkg::STATUS_OK;
         out_in.remote_code = 32'd0;
         out_in.last        = ctl.emit_last;
      end
      unique case (ctl.emit)
         rpte_pkg::EMIT_CTX:   out_in.word = context_ff;
         rpte_pkg::EMIT_ADDR:  out_in.word = address_ff;
         rpte_pkg::EMIT_COUNT: out_in.word = 32'(word_count_ff - CW'(1));
         rpte_pkg::EMIT_TAIL:  out_in.frame_end = 1'b1;
         rpte_pkg::EMIT_WDATA: out_in.word = item_ff.data_word;
         rpte_pkg::EMIT_RDATA: begin
            out_in.kind = rpte_pkg::KIND_RDATA;
            out_in.word = rd_data_ff;
         end
         rpte_pkg::EMIT_CPL: begin
            out_in.kind   = rpte_pkg::KIND_CPL;
            out_in.status = ctl.cpl_status;
            if (ctl.cpl_status == rpte_pkg::STATUS_REMOTE) begin
               out_in.remote_code = item_ff.data_word;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         write_mode_ff  <= 1'b0;
         posted_mode_ff <= 1'b0;
         word_count_ff  <= '0;
         tx_sent_ff     <= '0;
         rx_pos_ff      <= 16'd0;
         header_ok_ff   <= 1'b0;
         rd_idx_ff      <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         busy_ff        <= busy_in;
         write_mode_ff  <= write_mode_in;
         posted_mode_ff <= posted_mode_in;
         word_count_ff  <= word_count_in;
         tx_sent_ff     <= tx_sent_in;
         rx_pos_ff      <= rx_pos_in;
         header_ok_ff   <= header_ok_in;
         rd_idx_ff      <= rd_idx_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         item_ff <= req_payload;
      end
      context_ff <= context_in;
      address_ff <= address_in;
      out_ff     <= out_in;
   end

   // read buffer: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[buf_idx] <= item_ff.data_word;
      end
      if (ctl.fetch) begin
         rd_data_ff <= mem[rd_idx_ff[AW-1:0]];
      end
   end

   assign stat.command     = item_ff.command;
   assign stat.bad_size    = bad_size;
   assign stat.no_space    = no_space;
   assign stat.wdata_ok    = wdata_ok;
   assign stat.rsp_ok      = rsp_ok;
   assign stat.frame_done  = frame_done;
   assign stat.remote      = item_ff.data_word != 32'd0;
   assign stat.write_mode  = write_mode_ff;
   assign stat.posted_mode = posted_mode_ff;
   assign stat.tx_done     = tx_sent_ff == word_count_ff;
   assign stat.rd_last     = (rd_idx_ff + CW'(1)) == word_count_ff;
   assign stat.out_free    = out_free;

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      (ctl.emit != rpte_pkg::EMIT_NONE) |-> out_free)
      else $error("result loaded while output register is occupied");

   a_tx_within_count: assert property (@(posedge clock) disable iff (reset)
      tx_sent_ff <= word_count_ff)
      else $error("sent write words exceed word count");

   a_idle_rx_clear: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (rx_pos_ff == 16'd0))
      else $error("response position left nonzero while idle");

endmodule

>>> hw/rtl/rpte_controller.sv
// rpte_controller: sequencer that decodes each accepted item and steps the
// datapath through its result words. depends on rpte_pkg.
module rpte_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rpte_pkg::stat_type stat,
   output rpte_pkg::ctl_type  ctl
);

   rpte_pkg::state_type state_ff, state_in;
   logic [1:0]          cpl_status_ff, cpl_status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rpte_pkg::ST_IDLE;
         cpl_status_ff <= rpte_pkg::STATUS_OK;
      end else begin
         state_ff      <= state_in;
         cpl_status_ff <= cpl_status_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cpl_status_in  = cpl_status_ff;
      req_ready      = 1'b0;
      ctl.capture    = 1'b0;
      ctl.exec       = 1'b0;
      ctl.fetch      = 1'b0;
      ctl.rd_clear   = 1'b0;
      ctl.emit       = rpte_pkg::EMIT_NONE;
      ctl.emit_last  = 1'b0;
      ctl.cpl_status = cpl_status_ff;
      unique case (state_ff)
         rpte_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            ctl.capture = req_valid;
            if (req_valid) begin
               state_in = rpte_pkg::ST_DECODE;
            end
         end
         rpte_pkg::ST_DECODE: begin
            ctl.exec = 1'b1;
            state_in = rpte_pkg::ST_IDLE;
            unique case (stat.command)
               rpte_pkg::CMD_START: begin
                  if (stat.bad_size) begin
                     cpl_status_in = rpte_pkg::STATUS_BAD_SIZE;
                     state_in      = rpte_pkg::ST_CPL;
                  end else if (stat.no_space) begin
                     cpl_status_in = rpte_pkg::STATUS_NO_SPACE;
                     state_in      = rpte_pkg::ST_CPL;
                  end else begin
                     state_in = rpte_pkg::ST_HDR0;
                  end
               end
               rpte_pkg::CMD_WDATA: begin
                  if (stat.wdata_ok) begin
                     state_in = rpte_pkg::ST_WDATA;
                  end
               end
               rpte_pkg::CMD_RESP: begin
                  if (stat.rsp_ok && stat.frame_done) begin
                     if (stat.remote) begin
                        cpl_status_in = rpte_pkg::STATUS_REMOTE;
                        state_in      = rpte_pkg::ST_CPL;
                     end else if (!stat.write_mode) begin
                        cpl_status_in = rpte_pkg::STATUS_OK;
                        ctl.rd_clear  = 1'b1;
                        state_in      = rpte_pkg::ST_FETCH;
                     end else begin
                        cpl_status_in = rpte_pkg::STATUS_OK;
                        state_in      = rpte_pkg::ST_CPL;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         rpte_pkg::ST_HDR0: begin
            if (stat.out_free) begin
               ctl.emit = rpte_pkg::EMIT_CTX;
               state_in = rpte_pkg::ST_HDR1;
            end
         end
         rpte_pkg::ST_HDR1: begin
            if (stat.out_free) begin
               ctl.emit      = rpte_pkg::EMIT_ADDR;
               ctl.emit_last = stat.write_mode;
               state_in      = stat.write_mode ? rpte_pkg::ST_IDLE : rpte_pkg::ST_COUNT;
            end
         end
         rpte_pkg::ST_COUNT: begin
            if (stat.out_free) begin
               ctl.emit = rpte_pkg::EMIT_COUNT;
               state_in = rpte_pkg::ST_TAIL;
            end
         end
         rpte_pkg::ST_TAIL: begin
            if (stat.out_free) begin
               ctl.emit      = rpte_pkg::EMIT_TAIL;
               ctl.emit_last = !stat.posted_mode;
               if (stat.posted_mode) begin
                  cpl_status_in = rpte_pkg::STATUS_OK;
                  state_in      = rpte_pkg::ST_CPL;
               end else begin
                  state_in = rpte_pkg::ST_IDLE;
               end
            end
         end
         rpte_pkg::ST_WDATA: begin
            if (stat.out_free) begin
               ctl.emit      = rpte_pkg::EMIT_WDATA;
               ctl.emit_last = !stat.tx_done;
               state_in      = stat.tx_done ? rpte_pkg::ST_TAIL : rpte_pkg::ST_IDLE;
            end
         end
         rpte_pkg::ST_FETCH: begin
            ctl.fetch = 1'b1;
            state_in  = rpte_pkg::ST_RDATA;
         end
         rpte_pkg::ST_RDATA: begin
            if (stat.out_free) begin
               ctl.emit = rpte_pkg::EMIT_RDATA;
               state_in = stat.rd_last ? rpte_pkg::ST_CPL : rpte_pkg::ST_FETCH;
            end
         end
         rpte_pkg::ST_CPL: begin
            if (stat.out_free) begin
               ctl.emit      = rpte_pkg::EMIT_CPL;
               ctl.emit_last = 1'b1;
               state_in      = rpte_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rpte_pkg::ST_IDLE;
         end
      endcase
   end

   a_decode_after_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rpte_pkg::ST_DECODE) |-> ($past(state_ff) == rpte_pkg::ST_IDLE))
      else $error("decode entered without an accepted item");

   a_cpl_is_last: assert property (@(posedge clock) disable iff (reset)
      (ctl.emit == rpte_pkg::EMIT_CPL) |-> ctl.emit_last)
      else $error("completion not marked as final result");

endmodule

>>> tb/register_protocol_transaction_engine_core_tb.sv
// register_protocol_transaction_engine_core_tb: self-checking testbench for the register
// transaction engine; directed table, then random transactions checked by a predictor.
// depends on rpte_pkg, rpte_chan_if and register_protocol_transaction_engine_core.
module register_protocol_transaction_engine_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rpte_pkg::*;

   localparam int MAX_WORDS = rpte_pkg::MAX_WORDS_DEFAULT;

   // command code that the engine must ignore
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // receiver hold-off length, quiet-cycle limit and drain time at the end
   localparam int HOLD_CYCLES  = 400;
   localparam int QUIET_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 16;
   localparam int MISMATCH_PRINT_MAX = 100;

   // a frame this long pins the receive position at its ceiling
   localparam int LONG_FRAME_WORDS = 65544;

   // context and address shared by most of the directed transactions
   localparam logic [31:0] DIR_TID  = 32'h1234_5678;
   localparam logic [31:0] DIR_ADDR = 32'h0000_0104;

   // one directed row: the item, and where the expectation is written out here,
   // whether it is a single completion (with its status) or nothing at all
   typedef struct {
      req_payload_type item;
      bit              typed;
      bit              typed_cpl;
      logic [1:0]      typed_status;
   } stimulus_row_type;

   logic clock;
   logic reset;

   rpte_chan_if #(.payload_type(req_payload_type)) req_if ();
   rpte_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();

   register_protocol_transaction_engine_core #(
      .MAX_WORDS(MAX_WORDS)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   // engine state as the predictor sees it
   logic        eng_busy;
   logic        eng_write;
   logic        eng_posted;
   logic [31:0] eng_context;
   logic [31:0] eng_address;
   logic [5:0]  eng_words;
   logic [5:0]  eng_sent;
   logic [15:0] eng_rx_pos;
   logic        eng_header_ok;
   logic [31:0] eng_rd_buf [MAX_WORDS];

   // results of the last predicted item, and all results still owed by the engine
   rsp_payload_type produced[$];
   rsp_payload_type expected_results[$];

   int items_sent;
   int results_seen;
   int mismatches;
   int sender_idle_pct;
   int receiver_idle_pct;
   int holds_requested;

   stimulus_row_type directed[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      if (mismatches < MISMATCH_PRINT_MAX)
         $display("mismatch: %s", msg);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------

   function automatic void add_result(input logic [1:0] kind, input logic [31:0] word,
                                      input logic frame_end, input logic [1:0] status,
                                      input logic [31:0] code);
      rsp_payload_type r;
      r.kind        = kind;
      r.word        = word;
      r.frame_end   = frame_end;
      r.status      = status;
      r.remote_code = code;
      r.last        = 1'b0;
      produced.push_back(r);
   endfunction

   // works out the results that one accepted item causes and updates the state
   function automatic void predict_item(input req_payload_type r);
      logic [16:0] need;
      logic [16:0] total;
      logic [15:0] pos;
      int i;
      produced.delete();
      case (r.command)
         CMD_START: begin
            // any start drops whatever was running
            eng_busy      = 1'b0;
            eng_rx_pos    = '0;
            eng_header_ok = 1'b0;
            eng_sent      = '0;
            if (r.transfer_bytes[1:0] != 2'b00 || r.transfer_bytes < MIN_BYTES ||
                r.transfer_bytes > MAX_WORDS * 4) begin
               add_result(KIND_CPL, '0, 1'b0, STATUS_BAD_SIZE, '0);
            end else begin
               need = r.is_write ? {1'b0, r.transfer_bytes} + WRITE_HDR_BYTES
                                 : READ_REQ_BYTES;
               if ({1'b0, r.tx_space_bytes} < need) begin
                  add_result(KIND_CPL, '0, 1'b0, STATUS_NO_SPACE, '0);
               end else begin
                  eng_write   = r.is_write;
                  eng_posted  = r.posted;
                  eng_words   = r.transfer_bytes[7:2];
                  eng_context = r.tid;
                  eng_address = {1'b0, r.is_write, r.address[31:2]};
                  add_result(KIND_REQ, eng_context, 1'b0, STATUS_OK, '0);
                  add_result(KIND_REQ, eng_address, 1'b0, STATUS_OK, '0);
                  if (!r.is_write) begin
                     add_result(KIND_REQ, {26'd0, eng_words - 6'd1}, 1'b0, STATUS_OK, '0);
                     add_result(KIND_REQ, '0, 1'b1, STATUS_OK, '0);
                     if (r.posted)
                        add_result(KIND_CPL, '0, 1'b0, STATUS_OK, '0);
                     else
                        eng_busy = 1'b1;
                  end else begin
                     eng_busy = 1'b1;
                  end
               end
            end
         end
         CMD_WDATA: begin
            if (eng_busy && eng_write && eng_sent < eng_words) begin
               add_result(KIND_REQ, r.data_word, 1'b0, STATUS_OK, '0);
               eng_sent = eng_sent + 6'd1;
               if (eng_sent == eng_words) begin
                  add_result(KIND_REQ, '0, 1'b1, STATUS_OK, '0);
                  if (eng_posted) begin
                     add_result(KIND_CPL, '0, 1'b0, STATUS_OK, '0);
                     eng_busy = 1'b0;
                  end
               end
            end
         end
         CMD_RESP: begin
            if (eng_busy && !eng_posted && (!eng_write || eng_sent == eng_words)) begin
               pos = eng_rx_pos;
               if (pos == 16'd0)
                  eng_header_ok = (r.data_word == eng_context);
               else if (pos == 16'd1)
                  eng_header_ok = eng_header_ok && (r.data_word == eng_address);
               else if (!eng_write && pos - 16'd2 < {10'd0, eng_words})
                  eng_rd_buf[pos - 16'd2] = r.data_word;
               if (r.rx_last) begin
                  total      = {1'b0, pos} + 17'd1;
                  eng_rx_pos = '0;
                  if (total >= {11'd0, eng_words} + RSP_OVERHEAD && eng_header_ok) begin
                     if (r.data_word != '0) begin
                        add_result(KIND_CPL, '0, 1'b0, STATUS_REMOTE, r.data_word);
                     end else begin
                        if (!eng_write)
                           for (i = 0; i < eng_words; i++)
                              add_result(KIND_RDATA, eng_rd_buf[i], 1'b0, STATUS_OK, '0);
                        add_result(KIND_CPL, '0, 1'b0, STATUS_OK, '0);
                     end
                     eng_busy = 1'b0;
                  end
                  eng_header_ok = 1'b0;
               end else if (eng_rx_pos < RX_POS_MAX) begin
                  eng_rx_pos = eng_rx_pos + 16'd1;
               end
            end
         end
         default: ;
      endcase
      if (produced.size() > 0)
         produced[produced.size() - 1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------------------
   // item builders: fields an item does not use carry random values
   // ---------------------------------------------------------------------------

   function automatic req_payload_type noise_fields();
      req_payload_type r;
      r.command        = 2'($urandom_range(3));
      r.tid            = $urandom;
      r.address        = $urandom;
      r.transfer_bytes = 16'($urandom);
      r.is_write       = 1'($urandom);
      r.posted         = 1'($urandom);
      r.tx_space_bytes = 16'($urandom);
      r.data_word      = $urandom;
      r.rx_last        = 1'($urandom);
      return r;
   endfunction

   function automatic req_payload_type start_item(input logic [31:0] tid,
                                                  input logic [31:0] addr,
                                                  input logic [15:0] bytes,
                                                  input logic wr, input logic po,
                                                  input logic [15:0] space);
      req_payload_type r;
      r                = noise_fields();
      r.command        = CMD_START;
      r.tid            = tid;
      r.address        = addr;
      r.transfer_bytes = bytes;
      r.is_write       = wr;
      r.posted         = po;
      r.tx_space_bytes = space;
      return r;
   endfunction

   function automatic req_payload_type wdata_item(input logic [31:0] w);
      req_payload_type r;
      r           = noise_fields();
      r.command   = CMD_WDATA;
      r.data_word = w;
      return r;
   endfunction

   function automatic req_payload_type resp_item(input logic [31:0] w, input logic last_word);
      req_payload_type r;
      r           = noise_fields();
      r.command   = CMD_RESP;
      r.data_word = w;
      r.rx_last   = last_word;
      return r;
   endfunction

   function automatic stimulus_row_type table_row(input req_payload_type item, input bit typed,
                                                  input bit typed_cpl,
                                                  input logic [1:0] typed_status);
      stimulus_row_type row;
      row.item         = item;
      row.typed        = typed;
      row.typed_cpl    = typed_cpl;
      row.typed_status = typed_status;
      return row;
   endfunction

   // ---------------------------------------------------------------------------
   // driving
   // ---------------------------------------------------------------------------

   // offers one item after a random idle gap, waits for its transfer and then
   // records what it should cause
   task automatic transfer_item(input req_payload_type item, input bit typed,
                                input bit typed_cpl, input logic [1:0] typed_status);
      rsp_payload_type typed_rsp;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      items_sent++;
      // the predictor always runs so that its state follows the engine
      predict_item(item);
      if (typed) begin
         produced.delete();
         if (typed_cpl) begin
            typed_rsp        = '0;
            typed_rsp.kind   = KIND_CPL;
            typed_rsp.status = typed_status;
            typed_rsp.last   = 1'b1;
            produced.push_back(typed_rsp);
         end
      end
      foreach (produced[k])
         expected_results.push_back(produced[k]);
   endtask

   // response frame: context, address word, body, then the tail as final word
   task automatic send_frame(input logic [31:0] ctx, input logic [31:0] aw, input int len,
                             input logic [31:0] tail);
      logic [31:0] w;
      int p;
      for (p = 0; p < len; p++) begin
         if (p == len - 1)
            w = tail;
         else if (p == 0)
            w = ctx;
         else if (p == 1)
            w = aw;
         else
            w = $urandom;
         transfer_item(resp_item(w, p == len - 1), 1'b0, 1'b0, STATUS_OK);
      end
   endtask

   // one transaction with random content; when cut short, the next start drops it
   task automatic run_transaction(input bit cut_short);
      logic [31:0] tid;
      logic [31:0] addr;
      logic [31:0] aw;
      logic [31:0] bad_ctx;
      logic [31:0] bad_aw;
      logic [16:0] need;
      logic        wr;
      logic        po;
      int words;
      int i;
      tid   = $urandom;
      addr  = $urandom;
      wr    = 1'($urandom);
      po    = cut_short ? 1'b0 : ($urandom_range(3) == 0);
      // mostly short transfers, now and then up to the full buffer
      words = ($urandom_range(6) == 0) ? $urandom_range(MAX_WORDS, 1) : $urandom_range(4, 1);
      need  = wr ? 17'(words * 4) + WRITE_HDR_BYTES : READ_REQ_BYTES;
      aw    = {1'b0, wr, addr[31:2]};
      transfer_item(start_item(tid, addr, 16'(words * 4), wr, po,
                               16'($urandom_range(16'hFFFF, need))), 1'b0, 1'b0, STATUS_OK);
      if (cut_short) begin
         if (wr && words > 1)
            transfer_item(wdata_item($urandom), 1'b0, 1'b0, STATUS_OK);
         else if (!wr)
            transfer_item(resp_item(tid, 1'b0), 1'b0, 1'b0, STATUS_OK);
         return;
      end
      if (wr) begin
         // a response word before the write is fully sent is ignored
         if ($urandom_range(9) == 0)
            transfer_item(resp_item($urandom, 1'($urandom)), 1'b0, 1'b0, STATUS_OK);
         for (i = 0; i < words; i++)
            transfer_item(wdata_item($urandom), 1'b0, 1'b0, STATUS_OK);
      end else if ($urandom_range(9) == 0) begin
         // stray write data during a read
         transfer_item(wdata_item($urandom), 1'b0, 1'b0, STATUS_OK);
      end
      if (po) begin
         if ($urandom_range(9) == 0)
            transfer_item(resp_item($urandom, 1'($urandom)), 1'b0, 1'b0, STATUS_OK);
         return;
      end
      // sometimes a broken frame first: too short, or with a corrupted header word
      if ($urandom_range(4) == 0) begin
         if ($urandom_range(1) == 0) begin
            send_frame(tid, aw, $urandom_range(words + 2, 1), $urandom);
         end else begin
            bad_ctx = tid;
            bad_aw  = aw;
            if ($urandom_range(1) == 0)
               bad_ctx[$urandom_range(31)] = ~bad_ctx[$urandom_range(31)];
            else
               bad_aw = aw ^ (32'd1 << $urandom_range(31));
            if (bad_ctx == tid && bad_aw == aw)
               bad_aw = ~aw;
            send_frame(bad_ctx, bad_aw, words + 3, 32'd0);
         end
      end
      // good frame, sometimes with extra body words, mostly with a zero tail
      send_frame(tid, aw, words + 3 + (($urandom_range(9) == 0) ? $urandom_range(3, 1) : 0),
                 ($urandom_range(6) == 0) ? ($urandom | 32'd1) : 32'd0);
   endtask

   task automatic run_random_phase(input int item_target);
      logic [15:0] bytes;
      logic [16:0] need;
      logic        wr;
      int pick;
      int words;
      while (items_sent < item_target) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            run_transaction(1'b0);
         end else if (pick < 78) begin
            run_transaction(1'b1);
         end else if (pick < 86) begin
            // size that fails the check: zero, one word too many, or any value
            case ($urandom_range(2))
               0: bytes = '0;
               1: bytes = 16'(MAX_WORDS * 4 + 4);
               default: bytes = 16'($urandom);
            endcase
            if (bytes[1:0] == 2'b00 && bytes >= MIN_BYTES && bytes <= MAX_WORDS * 4)
               bytes = bytes + 16'd2;
            transfer_item(start_item($urandom, $urandom, bytes, 1'($urandom), 1'($urandom),
                                     16'($urandom)), 1'b0, 1'b0, STATUS_OK);
         end else if (pick < 93) begin
            // good size, too little room in the outgoing frame
            words = $urandom_range(MAX_WORDS, 1);
            wr    = 1'($urandom);
            need  = wr ? 17'(words * 4) + WRITE_HDR_BYTES : READ_REQ_BYTES;
            transfer_item(start_item($urandom, $urandom, 16'(words * 4), wr, 1'($urandom),
                                     16'($urandom_range(need - 1))), 1'b0, 1'b0, STATUS_OK);
         end else begin
            transfer_item(noise_fields(), 1'b0, 1'b0, STATUS_OK);
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // receiver: random ready, plus a long hold-off each time one is requested
   // ---------------------------------------------------------------------------

   initial begin : receiver
      int holds_done;
      holds_done = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_requested != holds_done) begin
            holds_done++;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // result checking: each transfer against the oldest expectation
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin : result_check
      rsp_payload_type got;
      rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result %0d with nothing expected: kind %0d word %h",
                                      results_seen, got.kind, got.word));
         end else begin
            want = expected_results.pop_front();
            if (got.kind !== want.kind)
               report_mismatch($sformatf("result %0d kind %0d, expected %0d",
                                         results_seen, got.kind, want.kind));
            if (got.word !== want.word)
               report_mismatch($sformatf("result %0d word %h, expected %h",
                                         results_seen, got.word, want.word));
            if (got.frame_end !== want.frame_end)
               report_mismatch($sformatf("result %0d frame_end %b, expected %b",
                                         results_seen, got.frame_end, want.frame_end));
            if (got.status !== want.status)
               report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                         results_seen, got.status, want.status));
            if (got.remote_code !== want.remote_code)
               report_mismatch($sformatf("result %0d remote_code %h, expected %h",
                                         results_seen, got.remote_code, want.remote_code));
            if (got.last !== want.last)
               report_mismatch($sformatf("result %0d last %b, expected %b",
                                         results_seen, got.last, want.last));
         end
         results_seen++;
      end
   end

   // ---------------------------------------------------------------------------
   // watchdog: too long without any transfer on either side ends the run
   // ---------------------------------------------------------------------------

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("no transfer for %0d cycles, %0d results still expected",
               QUIET_LIMIT, expected_results.size());
      $display("[register_protocol_transaction_engine_core] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------

   initial begin : main_sequence
      req_payload_type odd_item;
      logic [31:0] long_tid;
      logic [31:0] long_addr;
      int r;

      items_sent    = 0;
      results_seen  = 0;
      mismatches    = 0;
      eng_busy      = 1'b0;
      eng_write     = 1'b0;
      eng_posted    = 1'b0;
      eng_context   = '0;
      eng_address   = '0;
      eng_words     = '0;
      eng_sent      = '0;
      eng_rx_pos    = '0;
      eng_header_ok = 1'b0;
      foreach (eng_rd_buf[k])
         eng_rd_buf[k] = '0;

      // phase one: sender idles little, receiver a lot
      sender_idle_pct = 6;
      receiver_idle_pct <= 46;
      holds_requested <= 0;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table; expectations written out only for the obvious rows
      odd_item = noise_fields();
      odd_item.command = CMD_UNUSED;
      // nothing running: response word, write data and the unused command are ignored
      directed.push_back(table_row(resp_item(32'hFFFF_FFFF, 1'b1), 1, 0, STATUS_OK));
      directed.push_back(table_row(wdata_item(32'hFFFF_FFFF), 1, 0, STATUS_OK));
      directed.push_back(table_row(odd_item, 1, 0, STATUS_OK));
      // sizes that fail the check
      directed.push_back(table_row(start_item(DIR_TID, DIR_ADDR, 16'd0, 0, 0, 16'hFFFF),
                                   1, 1, STATUS_BAD_SIZE));
      directed.push_back(table_row(start_item(DIR_TID, DIR_ADDR, 16'd6, 1, 0, 16'hFFFF),
                                   1, 1, STATUS_BAD_SIZE));
      directed.push_back(table_row(start_item(DIR_TID, DIR_ADDR, 16'(MAX_WORDS * 4 + 4), 0, 1,
                                              16'hFFFF), 1, 1, STATUS_BAD_SIZE));
      directed.push_back(table_row(start_item(DIR_TID, DIR_ADDR, 16'hFFFF, 1, 1, 16'hFFFF),
                                   1, 1, STATUS_BAD_SIZE));
      // one byte short of room, for a read and for a full-size write
      directed.push_back(table_row(start_item(DIR_TID, DIR_ADDR, 16'd4, 0, 0, 16'd15),
                                   1, 1, STATUS_NO_SPACE));
      directed.push_back(table_row(start_item(DIR_TID, DIR_ADDR, 16'(MAX_WORDS * 4), 1, 0,
                                              16'(MAX_WORDS * 4 + 11)), 1, 1, STATUS_NO_SPACE));
      // posted read and posted write, all-ones and all-zeros headers, exact room
      directed.push_back(table_row(start_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd4, 0, 1, 16'd16),
                                   0, 0, STATUS_OK));
      directed.push_back(table_row(start_item(32'd0, 32'd0, 16'd4, 1, 1, 16'd16),
                                   0, 0, STATUS_OK));
      directed.push_back(table_row(wdata_item(32'hFFFF_FFFF), 0, 0, STATUS_OK));
      // all write words already sent: extra data is ignored
      directed.push_back(table_row(wdata_item(32'd0), 1, 0, STATUS_OK));
      // two-word read, a one-word frame that is too short, then the good frame
      directed.push_back(table_row(start_item(DIR_TID, DIR_ADDR, 16'd8, 0, 0, 16'hFFFF),
                                   0, 0, STATUS_OK));
      directed.push_back(table_row(resp_item(DIR_TID, 1'b1), 1, 0, STATUS_OK));
      directed.push_back(table_row(resp_item(DIR_TID, 1'b0), 0, 0, STATUS_OK));
      directed.push_back(table_row(resp_item({2'b00, DIR_ADDR[31:2]}, 1'b0), 0, 0, STATUS_OK));
      directed.push_back(table_row(resp_item(32'hFFFF_FFFF, 1'b0), 0, 0, STATUS_OK));
      directed.push_back(table_row(resp_item(32'd0, 1'b0), 0, 0, STATUS_OK));
      directed.push_back(table_row(resp_item(32'd0, 1'b1), 0, 0, STATUS_OK));
      // non-posted one-word write, answered with a remote error in the tail
      directed.push_back(table_row(start_item(DIR_TID, DIR_ADDR, 16'd4, 1, 0, 16'd16),
                                   0, 0, STATUS_OK));
      directed.push_back(table_row(wdata_item(32'hA5A5_5A5A), 0, 0, STATUS_OK));
      directed.push_back(table_row(resp_item(DIR_TID, 1'b0), 0, 0, STATUS_OK));
      directed.push_back(table_row(resp_item({2'b01, DIR_ADDR[31:2]}, 1'b0), 0, 0, STATUS_OK));
      directed.push_back(table_row(resp_item(32'hA5A5_5A5A, 1'b0), 0, 0, STATUS_OK));
      directed.push_back(table_row(resp_item(32'h8000_0000, 1'b1), 0, 0, STATUS_OK));

      for (r = 0; r < directed.size(); r++)
         transfer_item(directed[r].item, directed[r].typed, directed[r].typed_cpl,
                       directed[r].typed_status);

      // receiver stalls for a long stretch while items keep coming
      holds_requested <= 1;
      run_random_phase(items_sent + 85);

      // phase two: sender idles a lot, receiver little
      sender_idle_pct = 46;
      receiver_idle_pct <= 6;
      run_random_phase(items_sent + 85);

      // phase three: no idling on either side, one more long hold-off
      sender_idle_pct = 0;
      receiver_idle_pct <= 0;
      holds_requested <= 2;
      run_random_phase(items_sent + 85);

      // one-word read answered by a very long frame: the position count saturates
      long_tid  = $urandom;
      long_addr = $urandom;
      transfer_item(start_item(long_tid, long_addr, 16'd4, 1'b0, 1'b0, 16'hFFFF),
                    1'b0, 1'b0, STATUS_OK);
      send_frame(long_tid, {2'b00, long_addr[31:2]}, LONG_FRAME_WORDS, 32'd0);

      req_if.valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("[register_protocol_transaction_engine_core] OK");
      else
         $display("[register_protocol_transaction_engine_core] ERROR");
      $finish;
   end

endmodule
